// ===== hdl/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded substring search package
// Shared types and constants: status codes, register indexes and the
// configuration bundle handed from the register block to the datapath.
// ----------------------------------------------------------------------------
package bss_pkg;

    // Fixed field widths of the register file and the streams.
    localparam int NEEDLE_REG_BYTES = 16;
    localparam int LEN_BITS         = 5;
    localparam int LIMIT_BITS       = 16;
    localparam int MATCH_BITS       = 16;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 64;
    localparam int BYTE_BITS        = 8;

    // Search status as reported on every result word.
    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_NEEDLE_LOW   = 2'd0,
        CFG_NEEDLE_HIGH  = 2'd1,
        CFG_NEEDLE_LEN   = 2'd2,
        CFG_SEARCH_LIMIT = 2'd3
    } cfg_index_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [NEEDLE_REG_BYTES-1:0][BYTE_BITS-1:0] needle;
        logic [LEN_BITS-1:0]                        eff_len;
        logic [LIMIT_BITS-1:0]                      limit;
    } bss_cfg_t;

endpackage

// ===== hdl/bss_cfg.sv =====
// ----------------------------------------------------------------------------
// Bounded substring search register block
// Holds the needle, its length and the search limit, and keeps the
// effective needle length (capped, cut at the first zero byte) registered.
// ----------------------------------------------------------------------------
module bss_cfg
    import bss_pkg::*;
#(
    parameter int NEEDLE_MAX = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data,
    output bss_cfg_t                  cfg
);

    logic [CFG_DATA_BITS-1:0] needle_low_reg, needle_low_next;
    logic [CFG_DATA_BITS-1:0] needle_high_reg, needle_high_next;
    logic [LEN_BITS-1:0]      len_reg, len_next;
    logic [LIMIT_BITS-1:0]    limit_reg, limit_next;
    logic [LEN_BITS-1:0]      eff_len_reg, eff_len_next;
    logic [LEN_BITS-1:0]      len_cap;
    logic [NEEDLE_REG_BYTES-1:0][BYTE_BITS-1:0] bytes_next;

    // Register decode.
    always_comb
    begin
        needle_low_next  = needle_low_reg;
        needle_high_next = needle_high_reg;
        len_next         = len_reg;
        limit_next       = limit_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                CFG_NEEDLE_LOW:   needle_low_next  = wr_data;
                CFG_NEEDLE_HIGH:  needle_high_next = wr_data;
                CFG_NEEDLE_LEN:   len_next         = wr_data[LEN_BITS-1:0];
                CFG_SEARCH_LIMIT: limit_next       = wr_data[LIMIT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Effective length: capped at the window size and cut at the first
    // zero byte of the needle. The scan runs from the top so that the
    // lowest zero index wins.
    always_comb
    begin
        bytes_next = {needle_high_next, needle_low_next};
        if ({2'b00, len_next} > 7'(NEEDLE_MAX))
        begin
            len_cap = LEN_BITS'(NEEDLE_MAX);
        end
        else
        begin
            len_cap = len_next;
        end
        eff_len_next = len_cap;
        // Bytes past the register file read as zero, so the needle stops there.
        if (len_cap > LEN_BITS'(NEEDLE_REG_BYTES))
        begin
            eff_len_next = LEN_BITS'(NEEDLE_REG_BYTES);
        end
        for (int k = NEEDLE_REG_BYTES - 1; k >= 0; k--)
        begin
            if ((LEN_BITS'(k) < len_cap) && (bytes_next[k] == '0))
            begin
                eff_len_next = LEN_BITS'(k);
            end
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            len_reg         <= '0;
            limit_reg       <= '0;
            eff_len_reg     <= '0;
        end
        else if (wr_en)
        begin
            needle_low_reg  <= needle_low_next;
            needle_high_reg <= needle_high_next;
            len_reg         <= len_next;
            limit_reg       <= limit_next;
            eff_len_reg     <= eff_len_next;
        end
    end

    assign cfg.needle  = {needle_high_reg, needle_low_reg};
    assign cfg.eff_len = eff_len_reg;
    assign cfg.limit   = limit_reg;

endmodule

// ===== hdl/bss_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded substring search window cell
// One byte of the sliding window. Loads the byte handed on by its neighbor
// and compares that incoming byte with the needle byte aligned to it.
// ----------------------------------------------------------------------------
module bss_cell
    import bss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 clear,
    input  logic [BYTE_BITS-1:0] link_in,
    input  logic [BYTE_BITS-1:0] needle_byte,
    input  logic                 in_use,
    output logic [BYTE_BITS-1:0] win_byte,
    output logic                 match
);

    logic [BYTE_BITS-1:0] byte_reg, byte_next;

    // A shift loads the neighbor's byte; a new haystack alone clears it.
    always_comb
    begin
        if (shift)
        begin
            byte_next = link_in;
        end
        else if (clear)
        begin
            byte_next = '0;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // Cells outside the needle never block a hit.
    assign match    = !in_use || (link_in == needle_byte);
    assign win_byte = byte_reg;

endmodule

// ===== hdl/bounded_substring_search.sv =====
// ----------------------------------------------------------------------------
// Bounded substring search
// Scans a haystack streamed one byte per word for the first occurrence of
// a configured needle, within the search limit and before the first zero.
//
//   channel | direction | handshake         | contents
//   s_      | in        | s_tvalid/s_tready | tdata: hay_byte, tuser: start_search
//   m_      | out       | m_tvalid/m_tready | tdata: match_position, tuser: status
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while m_tready is high: every accepted word yields
// one result word on the next cycle; the window compare across the cell row
// is combinational. s_tready follows m_tready when the output register is full.
// Reset clears the window, position, outcome and all registers; no clearing
// pass is needed. Configuration writes are always ready and take effect for
// the next accepted word.
// ----------------------------------------------------------------------------
module bounded_substring_search
    import bss_pkg::*;
#(
    parameter int NEEDLE_MAX    = 16,
    parameter int POSITION_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] hay_byte
    input  logic                      s_tuser,   // [0] start_search
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,   // [15:0] match_position
    output logic [1:0]                m_tuser,   // [1:0] status
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CW = ((POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS) + 1;

    bss_cfg_t cfg;

    logic accept, start;
    logic [BYTE_BITS-1:0] hb;
    logic shift, clear, all_eq, hit;

    logic [NEEDLE_MAX-1:0][BYTE_BITS-1:0] win;
    logic [NEEDLE_MAX-1:0][BYTE_BITS-1:0] link;
    logic [NEEDLE_MAX-1:0][BYTE_BITS-1:0] aligned;
    logic [NEEDLE_MAX-1:0]                in_use;
    logic [NEEDLE_MAX-1:0]                cell_match;

    status_t                  outcome_reg, outcome_next, outcome_c;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, pos_c, pos_inc;
    logic [MATCH_BITS-1:0]    off_reg, off_next, off_c, off_hit;
    logic [CW-1:0]            p_w, p1_w, lim_w, n_w;
    logic                     at_limit, last_in, too_short;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [MATCH_BITS-1:0]    out_pos_reg;

    // Register block.
    assign cfg_ready = 1'b1;

    bss_cfg #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input handshake; the output register frees a slot when taken.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign start    = s_tuser;
    assign hb       = s_tdata;

    // Row of window cells; the newest byte enters at the top cell.
    for (genvar j = 0; j < NEEDLE_MAX; j++)
    begin : g_cell
        localparam int D = NEEDLE_MAX - j;
        logic [7:0] diff;

        // Needle byte aligned so that its last byte meets the newest byte.
        assign diff       = {3'b000, cfg.eff_len} - 8'(D);
        assign in_use[j]  = ({3'b000, cfg.eff_len} >= 8'(D));
        assign aligned[j] = cfg.needle[diff[3:0]];

        if (j == NEEDLE_MAX - 1)
        begin : g_top
            assign link[j] = hb;
        end
        else
        begin : g_mid
            assign link[j] = start ? '0 : win[j+1];
        end

        bss_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift       (shift),
            .clear       (clear),
            .link_in     (link[j]),
            .needle_byte (aligned[j]),
            .in_use      (in_use[j]),
            .win_byte    (win[j]),
            .match       (cell_match[j])
        );
    end

    // State as seen by this word, after a possible new-haystack clear.
    assign outcome_c = start ? ST_SEARCHING : outcome_reg;
    assign pos_c     = start ? '0 : pos_reg;
    assign off_c     = start ? '0 : off_reg;

    // Position compares against the limit and the needle length.
    assign p_w       = CW'(pos_c);
    assign p1_w      = p_w + CW'(1);
    assign lim_w     = CW'(cfg.limit);
    assign n_w       = CW'(cfg.eff_len);
    assign at_limit  = (p_w >= lim_w);
    assign last_in   = (p1_w >= lim_w);
    assign too_short = (p1_w < n_w);
    assign off_hit   = p1_w[MATCH_BITS-1:0] - n_w[MATCH_BITS-1:0];
    assign pos_inc   = (pos_c == '1) ? pos_c : pos_c + POSITION_BITS'(1);
    assign all_eq    = &cell_match;
    assign hit       = all_eq && !too_short;
    assign clear     = accept && start;

    // Search step.
    always_comb
    begin
        outcome_next = outcome_reg;
        pos_next     = pos_reg;
        off_next     = off_reg;
        shift        = 1'b0;
        if (accept)
        begin
            outcome_next = outcome_c;
            pos_next     = pos_c;
            off_next     = off_c;
            if (outcome_c == ST_SEARCHING)
            begin
                if (cfg.eff_len == '0)
                begin
                    outcome_next = ST_FOUND;
                    off_next     = '0;
                end
                else if ((hb == '0) || at_limit)
                begin
                    outcome_next = ST_NOT_FOUND;
                end
                else
                begin
                    shift    = 1'b1;
                    pos_next = pos_inc;
                    if (hit)
                    begin
                        outcome_next = ST_FOUND;
                        off_next     = off_hit;
                    end
                    else if (last_in)
                    begin
                        outcome_next = ST_NOT_FOUND;
                    end
                end
            end
        end
    end

    // Search state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outcome_reg    <= ST_SEARCHING;
            pos_reg        <= '0;
            off_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_SEARCHING;
            out_pos_reg    <= '0;
        end
        else
        begin
            outcome_reg <= outcome_next;
            pos_reg     <= pos_next;
            off_reg     <= off_next;
            if (accept)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= outcome_next;
                out_pos_reg    <= (outcome_next == ST_FOUND) ? off_next : '0;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_pos_reg;

    // A position is reported only with a found status.
    a_pos_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_FOUND)) |-> (m_tdata == '0))
        else $error("match position nonzero without found status");

    // A settled outcome holds until a new haystack starts.
    a_outcome_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !start && (outcome_reg != ST_SEARCHING)) |=>
        ((outcome_reg == $past(outcome_reg)) && (pos_reg == $past(pos_reg))))
        else $error("settled outcome changed without a new haystack");

    // The position never steps back within one haystack.
    a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !start) |=> (pos_reg >= $past(pos_reg)))
        else $error("byte position decreased within a haystack");

endmodule
